// ----- hdl/sie_pkg.sv -----
// Package for the stack integer evaluator: sizes, command and status codes, control structs.
package sie_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  // Command codes carried on the input tuser
  typedef enum logic [2:0] {
    CMD_BIPUSH = 3'd0,
    CMD_IADD   = 3'd1,
    CMD_ISUB   = 3'd2,
    CMD_IMUL   = 3'd3,
    CMD_FINISH = 3'd4
  } cmd_t;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic       push;        // write operand as new top, count up
    logic       rd_next;     // read the entry below the top
    logic       alu_wr;      // top <= add/sub result, count down
    logic       alu_sub;     // select top - next
    logic       mul_cap;     // capture top * next
    logic       mul_wr;      // top <= product, count down
    logic       clear;       // empty the stack
    logic       out_load;    // load the output register
    logic [1:0] out_status;  // status of the loaded result
    logic       out_report;  // result carries the top value
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic count_zero;
    logic count_lt2;
    logic count_full;
    logic out_free;          // output register empty or emptied this cycle
  } dp_stat_t;

endpackage

// ----- hdl/sie_datapath.sv -----
// Datapath of the stack integer evaluator: top register, stack memory, ALU, output register.
module sie_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  sie_pkg::ctl_cmd_t              ctl,
  output sie_pkg::dp_stat_t              stat,
  input  logic [sie_pkg::DATA_W-1:0]     operand_value,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sie_pkg::DATA_W-1:0]     m_tdata,
  output logic [2:0]                     m_tuser
);

  // Entries below the top live in memory; the top lives in a register
  logic [sie_pkg::DATA_W-1:0] stack_mem [sie_pkg::STACK_DEPTH];
  logic [sie_pkg::DATA_W-1:0] tos;
  logic [sie_pkg::DATA_W-1:0] rd_data;
  logic [sie_pkg::DATA_W-1:0] prod;
  logic [sie_pkg::CNT_W-1:0]  count;
  logic [sie_pkg::CNT_W-1:0]  cnt_m1;
  logic [sie_pkg::CNT_W-1:0]  cnt_m2;
  logic [sie_pkg::ADDR_W-1:0] top_idx;
  logic [sie_pkg::ADDR_W-1:0] next_idx;
  logic [sie_pkg::DATA_W-1:0] alu_res;
  logic [1:0]                 out_status;
  logic                       out_report;

  assign cnt_m1   = count - sie_pkg::CNT_W'(1);
  assign cnt_m2   = count - sie_pkg::CNT_W'(2);
  assign top_idx  = cnt_m1[sie_pkg::ADDR_W-1:0];
  assign next_idx = cnt_m2[sie_pkg::ADDR_W-1:0];

  // Add or subtract, top first
  assign alu_res = ctl.alu_sub ? (tos - rd_data) : (tos + rd_data);

  // Status flags for the controller
  assign stat.count_zero = (count == '0);
  assign stat.count_lt2  = (count < sie_pkg::CNT_W'(2));
  assign stat.count_full = (count == sie_pkg::CNT_W'(sie_pkg::STACK_DEPTH));
  assign stat.out_free   = !m_tvalid || m_tready;

  // Spill the old top into memory on push; read the next entry on request
  always_ff @(posedge clk) begin
    if (ctl.push && (count != '0)) begin
      stack_mem[top_idx] <= tos;
    end
    if (ctl.rd_next) begin
      rd_data <= stack_mem[next_idx];
    end
  end

  // Hold the product for one stage
  always_ff @(posedge clk) begin
    if (ctl.mul_cap) begin
      prod <= tos * rd_data;
    end
  end

  // Update the top register
  always_ff @(posedge clk) begin
    priority if (ctl.push) begin
      tos <= operand_value;
    end else if (ctl.alu_wr) begin
      tos <= alu_res;
    end else if (ctl.mul_wr) begin
      tos <= prod;
    end else begin
      tos <= tos;
    end
  end

  // Track the stack depth
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      priority if (ctl.clear) begin
        count <= '0;
      end else if (ctl.push) begin
        count <= count + sie_pkg::CNT_W'(1);
      end else if (ctl.alu_wr || ctl.mul_wr) begin
        count <= cnt_m1;
      end else begin
        count <= count;
      end
    end
  end

  // Output register: load a result, drop it once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status <= ctl.out_status;
      out_report <= ctl.out_report;
      m_tdata    <= ctl.out_report ? tos : '0;
    end
  end

  assign m_tuser = {out_report, out_status};

endmodule

// ----- hdl/sie_controller.sv -----
// Controller of the stack integer evaluator: command decode and sequencing.
module sie_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [2:0]        s_tuser,
  input  sie_pkg::dp_stat_t stat,
  output sie_pkg::ctl_cmd_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_MUL  = 3'b100
  } state_t;

  state_t        state;
  state_t        state_next;
  sie_pkg::cmd_t op;
  sie_pkg::cmd_t op_next;
  sie_pkg::cmd_t in_cmd;
  logic          accept;

  assign in_cmd   = sie_pkg::cmd_t'(s_tuser);
  assign s_tready = (state == S_IDLE) && stat.out_free;
  assign accept   = s_tvalid && s_tready;

  // Decode and sequence
  always_comb begin
    state_next = state;
    op_next    = op;
    ctl        = '0;
    ctl.out_status = sie_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            sie_pkg::CMD_BIPUSH: begin
              ctl.out_load = 1'b1;
              if (stat.count_full) begin
                ctl.out_status = sie_pkg::ST_OVERFLOW;
              end else begin
                ctl.push = 1'b1;
              end
            end
            sie_pkg::CMD_IADD, sie_pkg::CMD_ISUB, sie_pkg::CMD_IMUL: begin
              if (stat.count_lt2) begin
                ctl.out_load   = 1'b1;
                ctl.out_status = sie_pkg::ST_UNDERFLOW;
              end else begin
                ctl.rd_next = 1'b1;
                op_next     = in_cmd;
                state_next  = S_READ;
              end
            end
            sie_pkg::CMD_FINISH: begin
              ctl.clear    = 1'b1;
              ctl.out_load = 1'b1;
              if (stat.count_zero) begin
                ctl.out_status = sie_pkg::ST_UNDERFLOW;
              end else begin
                ctl.out_report = 1'b1;
              end
            end
            default: begin
              // unused codes leave the stack alone
              ctl.out_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (op == sie_pkg::CMD_IMUL) begin
          ctl.mul_cap = 1'b1;
          state_next  = S_MUL;
        end else begin
          ctl.alu_wr   = 1'b1;
          ctl.alu_sub  = (op == sie_pkg::CMD_ISUB);
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_MUL: begin
        ctl.mul_wr   = 1'b1;
        ctl.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= sie_pkg::CMD_BIPUSH;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

endmodule

// ----- hdl/stack_integer_evaluator_unit.sv -----
// Top level of the stack integer evaluator: stream ports, controller and datapath.
//
// A 32-bit operand-stack machine, sixteen entries deep. Each input transfer carries a
// command (push, add, subtract, multiply, finish) and returns exactly one result
// transfer with a status, a valid flag and, on finish, the popped top. Push, finish,
// unused codes and every underflow or overflow are answered from the idle state; add
// and subtract pass through a read state, because the entry under the top comes from
// the registered read of the stack memory; multiply also passes through a product
// state for the registered 32x32 product. The top of stack sits in a register, so only
// one memory read is needed per operation. A result held in the output register does
// not stop the next command from being taken in the cycle it is transferred out.
module stack_integer_evaluator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [sie_pkg::DATA_W-1:0] s_tdata,   // [31:0] operand_value
  input  logic [2:0]                 s_tuser,   // [2:0] cmd
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [sie_pkg::DATA_W-1:0] m_tdata,   // [31:0] result_value
  output logic [2:0]                 m_tuser    // [1:0] status, [2] result_valid
);

  sie_pkg::ctl_cmd_t ctl;
  sie_pkg::dp_stat_t stat;

  sie_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .ctl      (ctl)
  );

  sie_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .operand_value (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser)
  );

endmodule

// ----- test/stack_integer_evaluator_unit_test.sv -----
// Testbench for the stack integer evaluator: command streams checked against a stack model.
module stack_integer_evaluator_unit_test;

  localparam int CLK_HALF    = 6;
  localparam int RESET_LEN   = 7;
  localparam int ITEM_TARGET = 390;
  localparam int CALM_TAIL   = 60;
  localparam int DRAIN_WAIT  = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;

  // One input transfer: command code and operand
  typedef struct packed {
    logic [2:0]                 cmd;
    logic [sie_pkg::DATA_W-1:0] value;
  } command_t;

  // One result transfer
  typedef struct packed {
    logic [1:0]                 status;
    logic                       valid;
    logic [sie_pkg::DATA_W-1:0] value;
  } outcome_t;

  logic                       clk;
  logic                       rst      = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [sie_pkg::DATA_W-1:0] s_tdata  = '0;   // [31:0] operand_value
  logic [2:0]                 s_tuser  = '0;   // [2:0] cmd
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [sie_pkg::DATA_W-1:0] m_tdata;         // [31:0] result_value
  logic [2:0]                 m_tuser;         // [1:0] status, [2] result_valid

  command_t                   commands_pending[$];
  outcome_t                   results_due[$];

  // Model of the operand stack
  logic [sie_pkg::DATA_W-1:0] eval_stack[sie_pkg::STACK_DEPTH];
  int                         eval_depth = 0;

  int                         mismatches = 0;
  int                         cycles     = 0;
  int                         src_gap    = 0;
  int                         sink_gap   = 0;

  stack_integer_evaluator_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // No idling once the stream is nearly drained
  function automatic logic is_calm();
    return (commands_pending.size() < CALM_TAIL);
  endfunction

  // Apply one command to the stack model and queue the result it causes
  task automatic evaluate_command(input command_t c);
    outcome_t                   o;
    logic [sie_pkg::DATA_W-1:0] top;
    logic [sie_pkg::DATA_W-1:0] nxt;
    logic [sie_pkg::DATA_W-1:0] r;
    o        = '0;
    o.status = sie_pkg::ST_OK;
    case (c.cmd)
      sie_pkg::CMD_BIPUSH: begin
        if (eval_depth >= sie_pkg::STACK_DEPTH) begin
          o.status = sie_pkg::ST_OVERFLOW;
        end else begin
          eval_stack[eval_depth] = c.value;
          eval_depth++;
        end
      end
      sie_pkg::CMD_IADD, sie_pkg::CMD_ISUB, sie_pkg::CMD_IMUL: begin
        if (eval_depth < 2) begin
          o.status = sie_pkg::ST_UNDERFLOW;
        end else begin
          top = eval_stack[eval_depth-1];
          nxt = eval_stack[eval_depth-2];
          if (c.cmd == sie_pkg::CMD_IADD) r = top + nxt;
          else if (c.cmd == sie_pkg::CMD_ISUB) r = top - nxt;
          else r = top * nxt;
          eval_depth--;
          eval_stack[eval_depth-1] = r;
        end
      end
      sie_pkg::CMD_FINISH: begin
        if (eval_depth == 0) begin
          o.status = sie_pkg::ST_UNDERFLOW;
        end else begin
          o.valid = 1'b1;
          o.value = eval_stack[eval_depth-1];
        end
        eval_depth = 0;
      end
      default: ;
    endcase
    results_due.push_back(o);
  endtask

  task automatic queue_command(input logic [2:0] cmd,
                               input logic [sie_pkg::DATA_W-1:0] value);
    command_t c;
    c.cmd   = cmd;
    c.value = value;
    commands_pending.push_back(c);
  endtask

  // Operand mix: extremes, small numbers and full-range values
  function automatic logic [sie_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 6))
      0:       pick_value = {1'b0, {(sie_pkg::DATA_W-1){1'b1}}};
      1:       pick_value = {1'b1, {(sie_pkg::DATA_W-1){1'b0}}};
      2:       pick_value = '0;
      3:       pick_value = '1;
      4:       pick_value = $urandom_range(0, 15);
      5:       pick_value = -$urandom_range(1, 15);
      default: pick_value = $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_arith();
    case ($urandom_range(0, 2))
      0:       pick_arith = sie_pkg::CMD_IADD;
      1:       pick_arith = sie_pkg::CMD_ISUB;
      default: pick_arith = sie_pkg::CMD_IMUL;
    endcase
  endfunction

  // Well-formed expression: never pops below two entries, ends in finish
  task automatic queue_expression(input int max_steps);
    int depth;
    int steps;
    depth = 0;
    steps = $urandom_range(1, max_steps);
    for (int i = 0; i < steps; i++) begin
      if (depth < 2 || (depth < sie_pkg::STACK_DEPTH && $urandom_range(0, 1) == 1)) begin
        queue_command(sie_pkg::CMD_BIPUSH, pick_value());
        depth++;
      end else begin
        queue_command(pick_arith(), $urandom);
        depth--;
      end
    end
    queue_command(sie_pkg::CMD_FINISH, $urandom);
  endtask

  task automatic note_mismatch(input string what, input outcome_t want, input outcome_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display({"mismatch (%s): expected status %0d valid %0b value %h, ",
                "got status %0d valid %0b value %h"},
               what, want.status, want.valid, want.value, got.status, got.valid, got.value);
  endtask

  // Source side: hold a pending transfer, otherwise insert gaps or present the next command
  always @(posedge clk) begin : drive_proc
    logic holding;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      holding = 1'b0;
      if (s_tvalid && s_tready) evaluate_command(commands_pending.pop_front());
      else if (s_tvalid) holding = 1'b1;
      if (!holding) begin
        if (src_gap > 0 && !is_calm()) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (!is_calm() && commands_pending.size() > 0 &&
                     $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 4);
          s_tvalid <= 1'b0;
        end else if (commands_pending.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= commands_pending[0].value;
          s_tuser  <= commands_pending[0].cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: check each result transfer and stall in random bursts
  always @(posedge clk) begin : sink_proc
    outcome_t got;
    outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = m_tuser[1:0];
        got.valid  = m_tuser[2];
        got.value  = m_tdata;
        if (results_due.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = results_due.pop_front();
          if (want.status !== got.status) note_mismatch("status", want, got);
          if (want.valid !== got.valid) note_mismatch("result_valid", want, got);
          if (want.value !== got.value) note_mismatch("result_value", want, got);
        end
      end
      if (sink_gap > 0 && !is_calm()) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if (!is_calm() && $urandom_range(0, 6) == 0) begin
        sink_gap = $urandom_range(0, 4);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL stack_integer_evaluator_unit");
      $finish;
    end
  end

  initial begin : main_proc
    logic [sie_pkg::DATA_W-1:0] max_pos;
    logic [sie_pkg::DATA_W-1:0] min_neg;
    int                         fill;
    max_pos = {1'b0, {(sie_pkg::DATA_W-1){1'b1}}};
    min_neg = {1'b1, {(sie_pkg::DATA_W-1){1'b0}}};

    // Directed: empty-stack finish and arithmetic, single-entry arithmetic
    queue_command(sie_pkg::CMD_FINISH, '1);
    queue_command(sie_pkg::CMD_IADD, '0);
    queue_command(sie_pkg::CMD_BIPUSH, max_pos);
    queue_command(sie_pkg::CMD_ISUB, '1);
    // Wrapping add, multiply by minus one, subtract in top-minus-next order
    queue_command(sie_pkg::CMD_BIPUSH, max_pos);
    queue_command(sie_pkg::CMD_IADD, '0);
    queue_command(sie_pkg::CMD_BIPUSH, min_neg);
    queue_command(sie_pkg::CMD_IMUL, '0);
    queue_command(sie_pkg::CMD_BIPUSH, '1);
    queue_command(sie_pkg::CMD_IMUL, '0);
    queue_command(sie_pkg::CMD_BIPUSH, 32'd3);
    queue_command(sie_pkg::CMD_ISUB, '0);
    queue_command(sie_pkg::CMD_FINISH, '0);
    // Unused command codes leave the stack alone
    queue_command(sie_pkg::CMD_BIPUSH, 32'd7);
    for (int c = int'(sie_pkg::CMD_FINISH) + 1; c < 8; c++) queue_command(3'(c), '1);
    // Finish with entries left below the top
    queue_command(sie_pkg::CMD_BIPUSH, '0);
    queue_command(sie_pkg::CMD_FINISH, '0);
    queue_command(sie_pkg::CMD_FINISH, '0);

    // Random: mostly well-formed expressions, some overflow fills and noise
    while (commands_pending.size() < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: queue_expression(12);
        5:             queue_expression(40);
        6, 7: begin
          fill = sie_pkg::STACK_DEPTH + $urandom_range(0, 2);
          for (int i = 0; i < fill; i++) queue_command(sie_pkg::CMD_BIPUSH, pick_value());
          for (int i = 0; i < $urandom_range(0, 3); i++) queue_command(pick_arith(), $urandom);
          if ($urandom_range(0, 1) == 1) queue_command(sie_pkg::CMD_BIPUSH, pick_value());
          queue_command(sie_pkg::CMD_FINISH, $urandom);
        end
        default: begin
          for (int i = 0; i < $urandom_range(1, 6); i++)
            queue_command(3'($urandom_range(0, 7)), pick_value());
        end
      endcase
    end

    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;

    // Drain the stream, then allow for the pipeline
    while (commands_pending.size() != 0 || s_tvalid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("PASS stack_integer_evaluator_unit");
    end else begin
      $display("FAIL stack_integer_evaluator_unit");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sie_pkg.sv
hdl/sie_datapath.sv
hdl/sie_controller.sv
hdl/stack_integer_evaluator_unit.sv
test/stack_integer_evaluator_unit_test.sv
